// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a rising edge of i_clk.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/aes_cbc_pkg.sv
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// Types, codes, S-box tables and round functions of the AES-256 CBC engine.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        CMD_SINGLE  = 2'd0,
        CMD_CBC_ENC = 2'd1,
        CMD_CBC_DEC = 2'd2,
        CMD_MAC     = 2'd3
    } t_cmd;

    // Error codes of a result beat.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_PADDING = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW  = 3'd5;

    localparam int unsigned NUM_ROUNDS = 14;
    localparam logic [4:0]  FULL_BLOCK = 5'd16;
    localparam logic [7:0]  PAD_MARKER = 8'h80;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  plain_bytes;
        logic        final_result;
        logic [1:0]  error_code;
    } t_out_item;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // S-box applied to the four bytes of a key schedule word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    // One encryption round; the last round skips the column mix.
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last_round);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127-8*i -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[r+4*c] = SBOX_FWD[b[r+4*((c+r)%4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = (last_round ? t[i] : m[i]) ^ rk[127-8*i -: 8];
        end
        return o;
    endfunction

    // One decryption round; the last round skips the inverse column mix.
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last_round);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   x2;
        logic [7:0]   x4;
        logic [7:0]   x8;
        logic [7:0]   e [4];
        logic [7:0]   n [4];
        logic [7:0]   d [4];
        logic [7:0]   h [4];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127-8*i -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[r+4*((c+r)%4)] = SBOX_INV[b[r+4*c]] ^ rk[127-8*(r+4*((c+r)%4)) -: 8];
            end
        end
        // Multiples by 14, 9, 13 and 11 of each byte of a column.
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                x2   = xtime(t[4*c+j]);
                x4   = xtime(x2);
                x8   = xtime(x4);
                e[j] = x8 ^ x4 ^ x2;
                n[j] = x8 ^ t[4*c+j];
                d[j] = x8 ^ x4 ^ t[4*c+j];
                h[j] = x8 ^ x2 ^ t[4*c+j];
            end
            m[4*c]   = e[0] ^ h[1] ^ d[2] ^ n[3];
            m[4*c+1] = n[0] ^ e[1] ^ h[2] ^ d[3];
            m[4*c+2] = d[0] ^ n[1] ^ e[2] ^ h[3];
            m[4*c+3] = h[0] ^ d[1] ^ n[2] ^ e[3];
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = last_round ? t[i] : m[i];
        end
        return o;
    endfunction

endpackage

// File: src/aes256_cbc_pad_mac_engine_top.sv
// Flow: an accepted block gets its first key addition, then fourteen rounds, then a finish step
// that formats its beat (none for a non-final MAC block); padding a full final block adds a pad beat.
// The single shared AES round unit serves one block at a time, so no new beat is taken until
// the last leaves the finish step; a length error skips the rounds, and an untaken result beat
// holds the engine. A key or IV write re-expands the round keys, during which no beat is taken.
// Reset: synchronous active low; clears keys, IV and chain, then expands the zero key.
// ----------------------------------------------------------------------------
// aes256_cbc_pad_mac_engine_top
// AES-256 engine for single blocks, padded CBC encryption and decryption and CBC-MAC,
// built around one iterative round unit and a stored round key schedule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes256_cbc_pad_mac_engine_top
    import aes_cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        ST_KEYEXP,
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state       r_state;
    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_high;
    logic [63:0]  r_iv_low;
    logic [127:0] r_chain;
    logic         r_open;
    logic [127:0] r_rk [15];
    logic [255:0] r_kwin;
    logic [3:0]   r_kidx;
    logic [127:0] r_s;
    logic [127:0] r_xor;
    logic [3:0]   r_round;
    logic         r_dec;
    t_cmd         r_cmd;
    logic         r_last;
    logic         r_pad;
    logic         r_err;
    logic         r_ovalid;
    t_out_item    r_out;

    logic         cfg_wr;
    logic [2:0]   cfg_idx;
    logic         in_acc;
    logic [127:0] in_blk;
    logic [127:0] chain_eff;
    logic [127:0] padded;
    logic         len_err;
    logic [127:0] round_out;
    logic [31:0]  kx_t;
    logic [7:0]   kx_rcon;
    logic [31:0]  kx_w0;
    logic [31:0]  kx_w1;
    logic [31:0]  kx_w2;
    logic [31:0]  kx_w3;
    logic [127:0] fin_blk;
    logic [3:0]   pad_pos;
    logic         pad_ok;
    logic         emit;
    logic         fin_go;
    logic         out_load;
    t_out_item    fin_item;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = paddr[5:3];
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_KEY0:    prdata = r_key[0];
            REG_KEY1:    prdata = r_key[1];
            REG_KEY2:    prdata = r_key[2];
            REG_KEY3:    prdata = r_key[3];
            REG_IV_HIGH: prdata = r_iv_high;
            REG_IV_LOW:  prdata = r_iv_low;
            default:     prdata = 64'd0;
        endcase
    end

    // Next round key from the sliding window of the last eight schedule words.
    always_comb begin
        kx_rcon = 8'(8'h01 << (r_kidx[3:1] - 3'd1));
        if (r_kidx[0]) begin
            kx_t = sub_word(r_kwin[31:0]);
        end else begin
            kx_t = sub_word({r_kwin[23:0], r_kwin[31:24]}) ^ {kx_rcon, 24'd0};
        end
        kx_w0 = r_kwin[255:224] ^ kx_t;
        kx_w1 = r_kwin[223:192] ^ kx_w0;
        kx_w2 = r_kwin[191:160] ^ kx_w1;
        kx_w3 = r_kwin[159:128] ^ kx_w2;
    end

    // Input block preparation, padding and the length check.
    always_comb begin
        in_blk    = {i_in_item.block_high, i_in_item.block_low};
        chain_eff = r_open ? r_chain : {r_iv_high, r_iv_low};
        for (int i = 0; i < 16; i++) begin
            if (i_in_item.byte_count[3:0] == 4'(i)) begin
                padded[127-8*i -: 8] = PAD_MARKER;
            end else if (i_in_item.byte_count[3:0] < 4'(i)) begin
                padded[127-8*i -: 8] = 8'h00;
            end else begin
                padded[127-8*i -: 8] = in_blk[127-8*i -: 8];
            end
        end
        if (i_in_item.byte_count[4]) begin
            padded = in_blk;
        end
        len_err = (i_in_item.byte_count > FULL_BLOCK) ||
                  ((i_in_item.byte_count != FULL_BLOCK) &&
                   (!i_in_item.last || (i_in_item.command != CMD_CBC_ENC)));
    end

    // Shared round unit.
    assign round_out = r_dec ? dec_round(r_s, r_rk[r_round], r_round == 4'd0)
                             : enc_round(r_s, r_rk[r_round], r_round == 4'(NUM_ROUNDS));

    // Result formatting and the pad marker search on the final decrypted block.
    always_comb begin
        fin_blk = (r_cmd == CMD_CBC_DEC) ? (r_s ^ r_xor) : r_s;
        pad_pos = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (fin_blk[127-8*i -: 8] != 8'h00) begin
                pad_pos = 4'(i);
            end
        end
        pad_ok = (fin_blk[127-8*pad_pos -: 8] == PAD_MARKER);
        fin_item.out_high     = fin_blk[127:64];
        fin_item.out_low      = fin_blk[63:0];
        fin_item.plain_bytes  = FULL_BLOCK;
        fin_item.final_result = (r_cmd == CMD_SINGLE) || (r_last && !r_pad);
        fin_item.error_code   = ERR_NONE;
        if (r_err) begin
            fin_item.out_high     = 64'd0;
            fin_item.out_low      = 64'd0;
            fin_item.plain_bytes  = 5'd0;
            fin_item.final_result = 1'b1;
            fin_item.error_code   = ERR_LENGTH;
        end else if ((r_cmd == CMD_CBC_DEC) && r_last) begin
            fin_item.plain_bytes = pad_ok ? {1'b0, pad_pos} : 5'd0;
            fin_item.error_code  = pad_ok ? ERR_NONE : ERR_PADDING;
        end
        emit     = r_err || !((r_cmd == CMD_MAC) && !r_last);
        fin_go   = !emit || !r_ovalid || i_out_ready;
        out_load = (r_state == ST_FIN) && fin_go && emit && !cfg_wr;
    end

    // Sequencer, configuration, chain and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_KEYEXP;
            r_kidx    <= 4'd0;
            r_key[0]  <= 64'd0;
            r_key[1]  <= 64'd0;
            r_key[2]  <= 64'd0;
            r_key[3]  <= 64'd0;
            r_iv_high <= 64'd0;
            r_iv_low  <= 64'd0;
            r_chain   <= 128'd0;
            r_open    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_pad     <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            // The output beat is loaded from the finish step and cleared when taken.
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            // Register writes restart the key expansion.
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_KEY0:    r_key[0]  <= pwdata;
                    REG_KEY1:    r_key[1]  <= pwdata;
                    REG_KEY2:    r_key[2]  <= pwdata;
                    REG_KEY3:    r_key[3]  <= pwdata;
                    REG_IV_HIGH: r_iv_high <= pwdata;
                    REG_IV_LOW:  r_iv_low  <= pwdata;
                    default:     ;
                endcase
                r_state <= ST_KEYEXP;
                r_kidx  <= 4'd0;
            end else begin
                case (r_state)
                    ST_KEYEXP: begin
                        if (r_kidx == 4'd0) begin
                            r_kwin   <= {r_key[0], r_key[1], r_key[2], r_key[3]};
                            r_rk[0]  <= {r_key[0], r_key[1]};
                            r_rk[1]  <= {r_key[2], r_key[3]};
                            r_kidx   <= 4'd2;
                        end else begin
                            r_kwin       <= {r_kwin[127:0], kx_w0, kx_w1, kx_w2, kx_w3};
                            r_rk[r_kidx] <= {kx_w0, kx_w1, kx_w2, kx_w3};
                            r_kidx       <= r_kidx + 4'd1;
                            if (r_kidx == 4'(NUM_ROUNDS)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                    ST_IDLE: begin
                        if (in_acc) begin
                            r_cmd  <= i_in_item.command;
                            r_last <= i_in_item.last;
                            r_err  <= (i_in_item.command != CMD_SINGLE) && len_err;
                            r_pad  <= (i_in_item.command == CMD_CBC_ENC) && !len_err &&
                                      i_in_item.last && (i_in_item.byte_count == FULL_BLOCK);
                            r_dec  <= (i_in_item.command == CMD_CBC_DEC) && !len_err;
                            if (i_in_item.command == CMD_SINGLE) begin
                                r_s     <= in_blk ^ r_rk[0];
                                r_round <= 4'd1;
                                r_state <= ST_RUN;
                            end else if (len_err) begin
                                if (!r_open) begin
                                    r_chain <= {r_iv_high, r_iv_low};
                                end
                                r_open  <= 1'b0;
                                r_state <= ST_FIN;
                            end else begin
                                r_open  <= !i_in_item.last;
                                r_state <= ST_RUN;
                                case (i_in_item.command)
                                    CMD_CBC_ENC: begin
                                        r_s     <= padded ^ chain_eff ^ r_rk[0];
                                        r_round <= 4'd1;
                                        if (!r_open) begin
                                            r_chain <= {r_iv_high, r_iv_low};
                                        end
                                    end
                                    CMD_CBC_DEC: begin
                                        r_s     <= in_blk ^ r_rk[NUM_ROUNDS];
                                        r_xor   <= chain_eff;
                                        r_chain <= in_blk;
                                        r_round <= 4'(NUM_ROUNDS - 1);
                                    end
                                    default: begin
                                        r_s     <= in_blk ^ chain_eff ^ r_rk[0];
                                        r_round <= 4'd1;
                                        if (!r_open) begin
                                            r_chain <= {r_iv_high, r_iv_low};
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                    ST_RUN: begin
                        r_s <= round_out;
                        if (r_dec) begin
                            r_round <= r_round - 4'd1;
                            if (r_round == 4'd0) begin
                                r_state <= ST_FIN;
                            end
                        end else begin
                            r_round <= r_round + 4'd1;
                            if (r_round == 4'(NUM_ROUNDS)) begin
                                r_state <= ST_FIN;
                            end
                        end
                    end
                    ST_FIN: begin
                        if (fin_go) begin
                            if (out_load) begin
                                r_out <= fin_item;
                            end
                            if (!r_err && ((r_cmd == CMD_CBC_ENC) || (r_cmd == CMD_MAC))) begin
                                r_chain <= r_s;
                            end
                            // A full final block of padded encryption adds a pad-only block.
                            if (r_pad) begin
                                r_s     <= {PAD_MARKER, 120'd0} ^ r_s ^ r_rk[0];
                                r_round <= 4'd1;
                                r_pad   <= 1'b0;
                                r_state <= ST_RUN;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // Checks on the sequencer.
    `ASSERT_CLK(a_ready_only_idle, o_in_ready |-> (r_state == ST_IDLE), "ready outside idle")
    `ASSERT_CLK(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "beat not held")
    `ASSERT_CLK(a_rekey_on_write, cfg_wr |=> (r_state == ST_KEYEXP), "no key expansion")
    `ASSERT_NEVER(a_round_range, (r_state == ST_RUN) && (r_round > 4'(NUM_ROUNDS)), "round out of range")

endmodule

// File: tb/aes_engine_checker.sv
// ----------------------------------------------------------------------------
// aes_engine_checker
// Watches the input, output and register channels of the AES-256 CBC engine,
// predicts every result beat from its own cipher model and compares them.
// ----------------------------------------------------------------------------
module aes_engine_checker
    import aes_cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef logic [127:0] t_round_keys [15];

    logic [63:0]  key_reg [4];
    logic [127:0] iv_reg;
    logic [127:0] chain;
    logic         msg_open;
    t_out_item    expected_blocks [$];

    // Multiply in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    // Full AES-256 key schedule from the four key registers.
    function automatic t_round_keys schedule_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        t_round_keys rk;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = key_reg[i][63:32];
            w[2*i+1] = key_reg[i][31:0];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t  = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_times(rc, 8'h02);
            end else if (i % 8 == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++) begin
            rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        end
        return rk;
    endfunction

    // Byte substitution with row shift, forward or inverse.
    function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int           src;
        int           dst;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (!inv) begin
                    src = r + 4 * ((c + r) % 4);
                    dst = r + 4 * c;
                    o[127-8*dst -: 8] = SBOX_FWD[s[127-8*src -: 8]];
                end else begin
                    src = r + 4 * c;
                    dst = r + 4 * ((c + r) % 4);
                    o[127-8*dst -: 8] = SBOX_INV[s[127-8*src -: 8]];
                end
            end
        end
        return o;
    endfunction

    // Column mix, forward or inverse.
    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   m [4];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = s[127-8*(4*c+j) -: 8];
            end
            if (!inv) begin
                m = '{8'd2, 8'd3, 8'd1, 8'd1};
            end else begin
                m = '{8'd14, 8'd11, 8'd13, 8'd9};
            end
            for (int j = 0; j < 4; j++) begin
                o[127-8*(4*c+j) -: 8] = gf_times(a[0], m[(4-j)%4]) ^ gf_times(a[1], m[(5-j)%4])
                                      ^ gf_times(a[2], m[(6-j)%4]) ^ gf_times(a[3], m[(7-j)%4]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] cipher_fwd(input logic [127:0] s, input t_round_keys rk);
        s = s ^ rk[0];
        for (int r = 1; r < 14; r++) begin
            s = mix_columns(shift_sub(s, 1'b0), 1'b0) ^ rk[r];
        end
        return shift_sub(s, 1'b0) ^ rk[14];
    endfunction

    function automatic logic [127:0] cipher_inv(input logic [127:0] s, input t_round_keys rk);
        s = s ^ rk[14];
        for (int r = 13; r >= 1; r--) begin
            s = mix_columns(shift_sub(s, 1'b1) ^ rk[r], 1'b1);
        end
        return shift_sub(s, 1'b1) ^ rk[0];
    endfunction

    function automatic t_out_item make_result(input logic [127:0] b, input logic [4:0] pb,
                                              input logic fin, input logic [1:0] err);
        t_out_item o;
        o.out_high     = b[127:64];
        o.out_low      = b[63:0];
        o.plain_bytes  = pb;
        o.final_result = fin;
        o.error_code   = err;
        return o;
    endfunction

    // Work out the result beats that one accepted input beat causes.
    task automatic predict_block(input t_in_item it);
        t_round_keys  rk;
        logic [127:0] b;
        logic [127:0] d;
        int           k;
        rk = schedule_keys();
        b  = {it.block_high, it.block_low};
        if (it.command == CMD_SINGLE) begin
            expected_blocks.push_back(make_result(cipher_fwd(b, rk), FULL_BLOCK, 1'b1, ERR_NONE));
        end else begin
            if (!msg_open) begin
                chain = iv_reg;
            end
            if (it.byte_count > FULL_BLOCK ||
                (it.byte_count != FULL_BLOCK && (!it.last || it.command != CMD_CBC_ENC))) begin
                expected_blocks.push_back(make_result('0, 5'd0, 1'b1, ERR_LENGTH));
                msg_open = 1'b0;
            end else begin
                msg_open = !it.last;
                case (it.command)
                    CMD_CBC_ENC: begin
                        // Short final block: marker at byte_count, zeros after it.
                        if (it.byte_count < FULL_BLOCK) begin
                            for (int i = 0; i < 16; i++) begin
                                if (i == it.byte_count) begin
                                    b[127-8*i -: 8] = PAD_MARKER;
                                end else if (i > it.byte_count) begin
                                    b[127-8*i -: 8] = 8'h00;
                                end
                            end
                        end
                        chain = cipher_fwd(b ^ chain, rk);
                        expected_blocks.push_back(make_result(chain, FULL_BLOCK,
                            it.last && it.byte_count < FULL_BLOCK, ERR_NONE));
                        // Full final block adds a whole pad block.
                        if (it.last && it.byte_count == FULL_BLOCK) begin
                            chain = cipher_fwd({PAD_MARKER, 120'h0} ^ chain, rk);
                            expected_blocks.push_back(make_result(chain, FULL_BLOCK, 1'b1,
                                                                  ERR_NONE));
                        end
                    end
                    CMD_CBC_DEC: begin
                        d     = cipher_inv(b, rk) ^ chain;
                        chain = b;
                        if (!it.last) begin
                            expected_blocks.push_back(make_result(d, FULL_BLOCK, 1'b0,
                                                                  ERR_NONE));
                        end else begin
                            // Scan back over trailing zeros to the marker.
                            k = 15;
                            while (k > 0 && d[127-8*k -: 8] == 8'h00) begin
                                k--;
                            end
                            if (d[127-8*k -: 8] == PAD_MARKER) begin
                                expected_blocks.push_back(make_result(d, k[4:0], 1'b1,
                                                                      ERR_NONE));
                            end else begin
                                expected_blocks.push_back(make_result(d, 5'd0, 1'b1,
                                                                      ERR_PADDING));
                            end
                        end
                    end
                    default: begin
                        chain = cipher_fwd(b ^ chain, rk);
                        if (it.last) begin
                            expected_blocks.push_back(make_result(chain, FULL_BLOCK, 1'b1,
                                                                  ERR_NONE));
                        end
                    end
                endcase
            end
        end
    endtask

    // Track register writes, predict on input beats, compare on output beats.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] = '0;
            end
            iv_reg       = '0;
            chain        = '0;
            msg_open     = 1'b0;
            expected_blocks.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_KEY0:    key_reg[0]     = pwdata;
                    REG_KEY1:    key_reg[1]     = pwdata;
                    REG_KEY2:    key_reg[2]     = pwdata;
                    REG_KEY3:    key_reg[3]     = pwdata;
                    REG_IV_HIGH: iv_reg[127:64] = pwdata;
                    REG_IV_LOW:  iv_reg[63:0]   = pwdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_item);
                    o_fail_count++;
                end else begin
                    exp_item = expected_blocks.pop_front();
                    if (exp_item !== i_out_item) begin
                        $display("%0t: mismatch expected blk=%h_%h pb=%0d fin=%0d err=%0d",
                                 $time, exp_item.out_high, exp_item.out_low,
                                 exp_item.plain_bytes, exp_item.final_result,
                                 exp_item.error_code);
                        $display("%0t:          actual   blk=%h_%h pb=%0d fin=%0d err=%0d",
                                 $time, i_out_item.out_high, i_out_item.out_low,
                                 i_out_item.plain_bytes, i_out_item.final_result,
                                 i_out_item.error_code);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_block(i_in_item);
            end
        end
        o_pending = expected_blocks.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the AES-256 CBC engine: directed corner beats, then random
// messages of all commands under several key and IV settings, with random
// gaps on both channels, a long output stall and decrypt loopback of ciphertext.
// ----------------------------------------------------------------------------
module tb;
    import aes_cbc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          beats_sent;
    bit          long_hold;
    t_out_item   returned_blocks [$];

    aes256_cbc_pad_mac_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    aes_engine_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random stall before each beat, one long hold-off on request.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            returned_blocks.push_back(o_out_item);
        end
    end

    // Send one input beat after a random gap; valid stays high between beats only when the gap is zero.
    task automatic send_beat(input t_cmd cmd, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= '{command: cmd, block_high: hi, block_low: lo,
                        byte_count: cnt, last: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    // Stop offering beats and wait until every expected result has come.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_setting(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] ivh, input logic [63:0] ivl);
        drain();
        reg_write(REG_KEY0, k0);
        reg_write(REG_KEY1, k1);
        reg_write(REG_KEY2, k2);
        reg_write(REG_KEY3, k3);
        reg_write(REG_IV_HIGH, ivh);
        reg_write(REG_IV_LOW, ivl);
    endtask

    // Padded encryption of a random message, then decryption of its ciphertext.
    task automatic enc_dec_loopback(input int nblk, input logic [4:0] tail);
        t_out_item ct [$];
        drain();
        returned_blocks.delete();
        for (int i = 0; i < nblk; i++) begin
            send_beat(CMD_CBC_ENC, rand64(), rand64(),
                      (i == nblk - 1) ? tail : FULL_BLOCK, i == nblk - 1);
        end
        drain();
        ct = returned_blocks;
        for (int i = 0; i < ct.size(); i++) begin
            send_beat(CMD_CBC_DEC, ct[i].out_high, ct[i].out_low, FULL_BLOCK,
                      i == ct.size() - 1);
        end
    endtask

    // One random message: mostly well formed, some with broken lengths or mixed commands.
    task automatic random_message();
        int         nblk;
        int         kind;
        t_cmd       cmd;
        logic [4:0] cnt;
        kind = $urandom_range(0, 99);
        nblk = $urandom_range(1, 5);
        cmd  = t_cmd'($urandom_range(0, 3));
        if (kind < 25) begin
            enc_dec_loopback(nblk, 5'($urandom_range(0, 16)));
        end else begin
            for (int i = 0; i < nblk; i++) begin
                cnt = FULL_BLOCK;
                if (i == nblk - 1 && cmd == CMD_CBC_ENC) begin
                    cnt = 5'($urandom_range(0, 16));
                end
                if (kind >= 80) begin
                    // Broken length or a mid-message command change.
                    if ($urandom_range(0, 2) == 0) begin
                        cnt = 5'($urandom_range(0, 31));
                    end else begin
                        cmd = t_cmd'($urandom_range(1, 3));
                    end
                end
                if (cmd == CMD_SINGLE) begin
                    cnt = 5'($urandom_range(0, 31));
                end
                send_beat(cmd, rand64(), rand64(), cnt,
                          (i == nblk - 1) ? 1'b1 : 1'($urandom_range(0, 1) & (kind >= 80)));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        beats_sent  = 0;
        long_hold   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);

        // Directed beats with the reset key and IV.
        send_beat(CMD_SINGLE, '0, '0, FULL_BLOCK, 1'b1);
        send_beat(CMD_SINGLE, '1, '1, 5'd31, 1'b0);
        send_beat(CMD_CBC_ENC, '1, '1, FULL_BLOCK, 1'b1);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), 5'd0, 1'b1);
        send_beat(CMD_CBC_ENC, '1, '1, 5'd15, 1'b1);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), FULL_BLOCK, 1'b0);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), 5'd7, 1'b1);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), 5'd17, 1'b1);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), 5'd31, 1'b0);
        send_beat(CMD_CBC_ENC, rand64(), rand64(), 5'd8, 1'b0);
        send_beat(CMD_CBC_DEC, rand64(), rand64(), 5'd8, 1'b1);
        send_beat(CMD_MAC, rand64(), rand64(), 5'd15, 1'b1);
        send_beat(CMD_MAC, '0, '0, FULL_BLOCK, 1'b0);
        send_beat(CMD_MAC, '1, '1, FULL_BLOCK, 1'b1);
        send_beat(CMD_CBC_DEC, '0, '0, FULL_BLOCK, 1'b1);
        // Mixed commands inside one message.
        send_beat(CMD_CBC_ENC, rand64(), rand64(), FULL_BLOCK, 1'b0);
        send_beat(CMD_SINGLE, rand64(), rand64(), 5'd3, 1'b1);
        send_beat(CMD_CBC_DEC, rand64(), rand64(), FULL_BLOCK, 1'b1);
        enc_dec_loopback(2, 5'd0);
        enc_dec_loopback(1, FULL_BLOCK);

        // Extreme settings, then random ones.
        load_setting('1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 20; i++) random_message();
        load_setting('0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 20; i++) random_message();

        // Long receiver hold-off while beats keep coming.
        load_setting(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_beat(CMD_CBC_ENC, rand64(), rand64(), FULL_BLOCK, i == 11);
        end

        while (beats_sent < 1300) begin
            if ($urandom_range(0, 24) == 0) begin
                load_setting(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            end
            random_message();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
